// File: rtl/med_predictive_residual_core_defines.svh
// Assertion macros shared by the median edge detector residual block.
// Included by the top level only; relies on clk and rst_n being in scope.
`ifndef MED_PREDICTIVE_RESIDUAL_CORE_DEFINES_SVH
`define MED_PREDICTIVE_RESIDUAL_CORE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define MPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define MPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mpr_pkg.sv
// Package for the median edge detector residual block: widths, register
// indexes, payload types and the predictor function. No dependencies.
package mpr_pkg;

    localparam int PIX_W      = 8;
    localparam int RES_IN_W   = 16;
    localparam int RES_OUT_W  = 9;
    localparam int CFG_DIM_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = 13'd480;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0]           pixel_in;
        logic signed [RES_IN_W-1:0] residual_in;
    } sample_t;

    typedef struct packed {
        logic signed [RES_OUT_W-1:0] residual_out;
        logic [PIX_W-1:0]            pixel_out;
        logic                        row_end;
        logic                        frame_end;
    } result_t;

    // Median edge detector: a is left, b is up, c is upper-left.
    function automatic logic [PIX_W-1:0] med_predict(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c
    );
        logic [PIX_W-1:0] mx;
        logic [PIX_W-1:0] mn;
        logic [PIX_W+1:0] grad;
        mx   = (a > b) ? a : b;
        mn   = (a > b) ? b : a;
        grad = {2'b00, a} + {2'b00, b} - {2'b00, c};
        if (c >= mx)
        begin
            return mn;
        end
        else if (c <= mn)
        begin
            return mx;
        end
        else
        begin
            // c lies strictly between the neighbours, so the gradient stays in range.
            return grad[PIX_W-1:0];
        end
    endfunction

endpackage

// File: rtl/mpr_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Used for both channels of the residual block; no package dependency.
interface mpr_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/mpr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined until written.
module mpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/med_predictive_residual_core.sv
// Median edge detector predictor and residual stage (top level).
// Depends on mpr_pkg, mpr_stream_if, mpr_ram and the assertion macro header.
//
// Usage:
//   Pixels (encode) or residuals (decode) enter on the sample channel in
//   raster order, one transaction per pixel. Each yields one transaction on
//   the result channel: residual, pixel, and row and frame end flags.
//   The wr_en/wr_index/wr_data port sets direction, width and height; the user
//   must write it only while no transaction is in flight. The block itself
//   does not enforce this. The line store is read at the accept edge, as the
//   sample enters the working stage; the result then goes to the output register.
// Throughput: one transaction per cycle unless the receiver stalls. The previous
//   row sits in a single RAM, read at accept time and written from the working
//   stage; a same-cycle write and read of a column (one-pixel rows) is forwarded.
// Reset: counters, neighbour registers and the pipeline clear; the line
//   store is not cleared, as data read for the first row is not used.
// Stall: when the receiver holds ready low the output register keeps its
//   transaction, the working stage holds and the sample channel drops ready
//   only once both are full.
`include "med_predictive_residual_core_defines.svh"

module med_predictive_residual_core
    import mpr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    mpr_stream_if.sink            sample,
    mpr_stream_if.source          result
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WCMP_W = (CFG_DIM_W > COL_W + 1) ? CFG_DIM_W : COL_W + 1;
    localparam int HCMP_W = (CFG_DIM_W > ROW_W + 1) ? CFG_DIM_W : ROW_W + 1;
    localparam logic [WCMP_W-1:0] MAXW_EXT = WCMP_W'(MAX_WIDTH);
    localparam logic [HCMP_W-1:0] MAXH_EXT = HCMP_W'(MAX_HEIGHT);
    localparam int SUM_W = RES_IN_W + 1;

    // Configuration registers
    logic                 dir_reg;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;

    // Position counters and neighbours
    logic [COL_W-1:0] col_reg,  col_next;
    logic [ROW_W-1:0] row_reg,  row_next;
    logic [PIX_W-1:0] left_reg, left_next;
    logic [PIX_W-1:0] ul_reg,   ul_next;

    // Working stage
    logic                       s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0]           s1_col_reg;
    logic                       s1_first_col_reg;
    logic                       s1_first_row_reg;
    logic                       s1_row_end_reg;
    logic                       s1_frame_end_reg;
    logic [PIX_W-1:0]           s1_pixel_reg;
    logic signed [RES_IN_W-1:0] s1_residual_reg;
    logic                       fwd_hit_reg;
    logic [PIX_W-1:0]           fwd_data_reg;

    // Output register
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    logic                    sample_fire;
    logic                    s1_fire;
    logic [WCMP_W-1:0]       width_ext;
    logic [WCMP_W-1:0]       width_last;
    logic [HCMP_W-1:0]       height_ext;
    logic [HCMP_W-1:0]       height_last;
    logic                    row_end_s0;
    logic                    frame_end_s0;
    logic [PIX_W-1:0]        ram_rdata;
    logic [PIX_W-1:0]        up_raw;
    logic [PIX_W-1:0]        nb_a;
    logic [PIX_W-1:0]        nb_b;
    logic [PIX_W-1:0]        nb_c;
    logic [PIX_W-1:0]        pred;
    logic signed [SUM_W-1:0] dec_sum;
    logic [PIX_W-1:0]        dec_pixel;
    logic [PIX_W-1:0]        x_pixel;
    logic [RES_OUT_W-1:0]    x_residual;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg    <= DIR_ENCODE;
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_DIRECTION: dir_reg    <= wr_data[0];
                REG_WIDTH:     width_reg  <= wr_data[CFG_DIM_W-1:0];
                REG_HEIGHT:    height_reg <= wr_data[CFG_DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // Last column and row index, with zero acting as one and oversize clipped.
    always_comb
    begin
        width_ext  = WCMP_W'(width_reg);
        height_ext = HCMP_W'(height_reg);
        if (width_ext == '0)
        begin
            width_last = '0;
        end
        else if (width_ext > MAXW_EXT)
        begin
            width_last = MAXW_EXT - WCMP_W'(1);
        end
        else
        begin
            width_last = width_ext - WCMP_W'(1);
        end
        if (height_ext == '0)
        begin
            height_last = '0;
        end
        else if (height_ext > MAXH_EXT)
        begin
            height_last = MAXH_EXT - HCMP_W'(1);
        end
        else
        begin
            height_last = height_ext - HCMP_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign s1_fire      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_fire;
    assign sample_fire  = sample.valid && sample.ready;

    // ---------------------------------------------------------------
    // Accept: position bookkeeping and line-store read
    // ---------------------------------------------------------------
    assign row_end_s0   = WCMP_W'(col_reg) >= width_last;
    assign frame_end_s0 = row_end_s0 && (HCMP_W'(row_reg) >= height_last);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (sample_fire)
        begin
            if (row_end_s0)
            begin
                col_next = '0;
                row_next = frame_end_s0 ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    mpr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (x_pixel),
        .re    (sample_fire),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    assign s1_valid_next = sample_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            if (sample_fire)
            begin
                // The column being written this cycle is read back as stale data.
                fwd_hit_reg <= s1_fire && (s1_col_reg == col_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            s1_col_reg       <= col_reg;
            s1_first_col_reg <= (col_reg == '0);
            s1_first_row_reg <= (row_reg == '0);
            s1_row_end_reg   <= row_end_s0;
            s1_frame_end_reg <= frame_end_s0;
            s1_pixel_reg     <= sample.data.pixel_in;
            s1_residual_reg  <= sample.data.residual_in;
            fwd_data_reg     <= x_pixel;
        end
    end

    // ---------------------------------------------------------------
    // Working stage: prediction, reconstruction and write-back
    // ---------------------------------------------------------------
    always_comb
    begin
        up_raw = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        nb_a   = s1_first_col_reg ? '0 : left_reg;
        nb_b   = s1_first_row_reg ? '0 : up_raw;
        nb_c   = (s1_first_col_reg || s1_first_row_reg) ? '0 : ul_reg;
        pred   = med_predict(nb_a, nb_b, nb_c);

        dec_sum = SUM_W'(s1_residual_reg) + $signed({{(SUM_W-PIX_W){1'b0}}, pred});
        if (dec_sum < 0)
        begin
            dec_pixel = '0;
        end
        else if (dec_sum > $signed(SUM_W'(PIX_MAX)))
        begin
            dec_pixel = PIX_MAX;
        end
        else
        begin
            dec_pixel = dec_sum[PIX_W-1:0];
        end

        x_pixel    = (dir_reg == DIR_DECODE) ? dec_pixel : s1_pixel_reg;
        x_residual = {1'b0, x_pixel} - {1'b0, pred};

        left_next = left_reg;
        ul_next   = ul_reg;
        if (s1_fire)
        begin
            left_next = s1_row_end_reg ? '0 : x_pixel;
            ul_next   = s1_row_end_reg ? '0 : nb_b;
        end
    end

    assign out_valid_next = s1_fire ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            ul_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            ul_reg        <= ul_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg.residual_out <= $signed(x_residual);
            out_data_reg.pixel_out    <= x_pixel;
            out_data_reg.row_end      <= s1_row_end_reg;
            out_data_reg.frame_end    <= s1_frame_end_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `MPR_ASSERT_NEXT(a_fwd_same_column,
        sample_fire && s1_fire && (s1_col_reg == col_reg), fwd_hit_reg,
        "line-store collision was not forwarded")
    `MPR_ASSERT_NEXT(a_stage_holds,
        s1_valid_reg && !s1_fire, s1_valid_reg && $stable(s1_col_reg),
        "working stage lost its transaction while stalled")
    `MPR_ASSERT_NEXT(a_row_wraps,
        sample_fire && row_end_s0, col_reg == '0,
        "column counter did not wrap at the end of a row")
    `MPR_ASSERT_SAME(a_frame_implies_row,
        out_valid_reg && out_data_reg.frame_end, out_data_reg.row_end,
        "frame end flagged away from a row end")

endmodule
